// ===== hdl/upd_pkg.sv =====
package upd_pkg;

  // Characters that the escape decoding looks for
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] ChUpperA  = 8'h41;
  localparam logic [7:0] CaseMask  = 8'hDF;

  // Most decoded bytes that one input byte can release
  localparam int unsigned MaxResults = 3;

  // Escape phase: what the decoder is holding back
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,  // nothing held
    PH_PCT   = 2'd1,  // a percent sign is held
    PH_DIGIT = 2'd2   // a percent sign and one hex digit are held
  } phase_e;

  // Result of decoding one input byte
  typedef struct packed {
    logic [1:0]                      count;    // number of bytes released
    logic [MaxResults-1:0][7:0]      bytes;    // released bytes, entry 0 first
    logic [MaxResults-1:0]           lasts;    // end-of-string mark per entry
    phase_e                          phase;    // phase after this byte
    logic                            held_we;  // capture the byte as held digit
  } dec_result_t;

  function automatic logic is_hex(input logic [7:0] b);
    logic [7:0] u;
    u = b & CaseMask;
    return ((b >= ChZero) && (b <= ChNine)) ||
           ((u >= ChUpperA) && (u <= ChUpperA + 8'd5));
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    if (b <= ChNine) begin
      v = b - ChZero;
    end else begin
      v = (b & CaseMask) - ChUpperA + 8'd10;
    end
    return v[3:0];
  endfunction

endpackage

// ===== hdl/upd_in_if.sv =====
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== hdl/upd_out_if.sv =====
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/upd_decode.sv =====
module upd_decode (
  input  upd_pkg::phase_e      phase_i,
  input  logic [7:0]           held_i,
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  output upd_pkg::dec_result_t res_o
);
  import upd_pkg::*;

  dec_result_t res;
  logic [1:0]  n;
  logic        as_idle;
  logic        b_hex;
  logic [7:0]  value;

  assign b_hex = is_hex(byte_i);
  assign value = {hex_value(held_i), hex_value(byte_i)};

  // Decode one byte against the held escape bytes
  always_comb begin
    res     = '0;
    n       = 2'd0;
    as_idle = 1'b0;
    res.phase = PH_IDLE;

    unique case (phase_i)
      PH_PCT: begin
        if (byte_i == ChPercent) begin
          res.bytes[n] = ChPercent; n = n + 2'd1;
        end else if (b_hex && !last_i) begin
          res.held_we = 1'b1;
          res.phase   = PH_DIGIT;
        end else begin
          res.bytes[n] = ChPercent; n = n + 2'd1;
          res.bytes[n] = byte_i;    n = n + 2'd1;
        end
      end
      PH_DIGIT: begin
        if (b_hex) begin
          if (value != 8'd0) begin
            res.bytes[n] = value; n = n + 2'd1;
          end else begin
            // zero escape passes through unchanged
            res.bytes[n] = ChPercent; n = n + 2'd1;
            res.bytes[n] = held_i;    n = n + 2'd1;
            res.bytes[n] = byte_i;    n = n + 2'd1;
          end
        end else begin
          res.bytes[n] = ChPercent; n = n + 2'd1;
          res.bytes[n] = held_i;    n = n + 2'd1;
          as_idle = 1'b1;
        end
      end
      default: begin
        as_idle = 1'b1;
      end
    endcase

    // Ordinary byte handling; a percent sign opens an escape unless it ends the string
    if (as_idle) begin
      if ((byte_i == ChPercent) && !last_i) begin
        res.phase = PH_PCT;
      end else begin
        res.bytes[n] = byte_i; n = n + 2'd1;
        res.phase = PH_IDLE;
      end
    end

    // End of string: flush, mark the final byte
    if (last_i) begin
      res.phase = PH_IDLE;
      if (n != 2'd0) begin
        res.lasts[n - 2'd1] = 1'b1;
      end
    end

    res.count = n;
  end

  assign res_o = res;

endmodule

// ===== hdl/url_percent_decoder.sv =====
// Percent-escape decoder, one raw byte per transfer in, decoded bytes out.
// The first decoded byte of an input byte is offered in the cycle after its transfer.
// Takes one input byte per cycle while out_o is ready and each byte releases at most one;
// one releasing 2 or 3 holds the input while the three-entry result register drains.
// Reset (rst_ni, asynchronous, active low) empties the result register and clears the
// escape phase; the held digit register is not reset.
module url_percent_decoder (
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);
  import upd_pkg::*;

  phase_e                     phase_q, phase_d;
  logic [7:0]                 held_q;
  logic [MaxResults-1:0][7:0] bytes_q, bytes_d;
  logic [MaxResults-1:0]      lasts_q, lasts_d;
  logic [1:0]                 rem_q, rem_d;
  dec_result_t                dec;
  logic                       in_xfer;
  logic                       out_xfer;

  upd_decode u_decode (
    .phase_i (phase_q),
    .held_i  (held_q),
    .byte_i  (in_i.in_byte),
    .last_i  (in_i.in_last),
    .res_o   (dec)
  );

  // Handshakes: take input once the result register is empty or empties this cycle
  assign out_o.valid    = (rem_q != 2'd0);
  assign out_o.out_byte = bytes_q[0];
  assign out_o.out_last = lasts_q[0];
  assign out_xfer       = out_o.valid && out_o.ready;
  assign in_i.ready     = (rem_q == 2'd0) || ((rem_q == 2'd1) && out_o.ready);
  assign in_xfer        = in_i.valid && in_i.ready;

  // Result register: load on input transfer, shift down on output transfer
  always_comb begin
    phase_d = phase_q;
    bytes_d = bytes_q;
    lasts_d = lasts_q;
    rem_d   = rem_q;
    if (in_xfer) begin
      phase_d = dec.phase;
      bytes_d = dec.bytes;
      lasts_d = dec.lasts;
      rem_d   = dec.count;
    end else if (out_xfer) begin
      bytes_d = {8'd0, bytes_q[MaxResults-1:1]};
      lasts_d = {1'b0, lasts_q[MaxResults-1:1]};
      rem_d   = rem_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      rem_q   <= 2'd0;
      lasts_q <= '0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      lasts_q <= lasts_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    if (in_xfer && dec.held_we) begin
      held_q <= in_i.in_byte;
    end
  end

endmodule
